FILE: rtl/ccKB_pkg.sv
// ============================================================================
// ccKB_pkg - shared types and constants for the clipped color-key blit
// Holds the field widths, the beat structs of both channels, the register
// indexes of the configuration port and the size clamp used on writes.
// ============================================================================
package ccKB_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int PIXEL_BYTES = 4;

    localparam int DIM_W    = 13;
    localparam int POS_W    = 14;
    localparam int STRIDE_W = 15;
    localparam int ADDR_W   = 26;
    localparam int PIX_W    = 32;
    localparam int KEY_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0] MAX_DIM_VAL = DIM_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_POS_X      = 3'd4,
        REG_POS_Y      = 3'd5,
        REG_DST_STRIDE = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] src_pixel;
        logic             first;
    } ccKB_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dst_address;
        logic [PIX_W-1:0]  write_pixel;
    } ccKB_out_t;

    typedef struct packed {
        logic [DIM_W-1:0]    src_width;
        logic [DIM_W-1:0]    src_height;
        logic [DIM_W-1:0]    dst_width;
        logic [DIM_W-1:0]    dst_height;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [STRIDE_W-1:0] dst_stride;
    } ccKB_cfg_t;

    // One pixel held in the input register with its source coordinates.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
    } ccKB_stage_t;

    // Keep the low DIM_W bits of a written size, then saturate it to MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] value);
        logic [DIM_W-1:0] v;
        v = value[DIM_W-1:0];
        return (v > MAX_DIM_VAL) ? MAX_DIM_VAL : v;
    endfunction

endpackage

FILE: rtl/clipped_color_key_blit_unit.sv
// ============================================================================
// clipped_color_key_blit_unit - color-keyed sprite blit with clipping
// Turns a raster stream of source pixels into destination write beats.
// ============================================================================
// Usage:
//   Program the seven registers on the cfg channel while the block is idle;
//   cfg_ready is always high and a write to an unused index is dropped.
//   Written sizes keep their low DIM_W bits, then saturate at MAX_DIM.
//   Send source pixels in raster order on the in channel, with first set on
//   the top-left pixel of each image. Each beat advances the column and row
//   counters; after the last pixel of an image the counters hold and all
//   further pixels are dropped until a beat with first set.
//   A pixel whose destination lies inside the destination image and whose
//   low byte is non-zero leaves on the out channel as one beat carrying the
//   byte address and the pixel; every other pixel produces no beat.
//   An input beat passes the input register, then the result register, to
//   out_valid. Throughput: one pixel per clock while out_ready stays high,
//   set by the single counter update per accepted beat; the input and result
//   registers each take a new beat in the cycle their contents move on.
//   When out_ready is low the result beat holds, the input register still
//   fills, and in_ready drops only once both are occupied.
//   Reset clears the configuration, the counters and both valid flags.
// ============================================================================
module clipped_color_key_blit_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccKB_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccKB_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  ccKB_pkg::ccKB_in_t                  in_data,

    output logic                                out_valid,
    input  logic                                out_ready,
    output ccKB_pkg::ccKB_out_t                 out_data
);

    ccKB_pkg::ccKB_cfg_t           cfg_reg;
    logic [ccKB_pkg::DIM_W-1:0]    col_count_reg, col_count_next;
    logic [ccKB_pkg::DIM_W-1:0]    row_count_reg, row_count_next;
    logic                          s1_valid_reg;
    ccKB_pkg::ccKB_stage_t         s1_reg, s1_next;
    logic                          out_valid_reg;
    ccKB_pkg::ccKB_out_t           out_reg, out_next;

    logic                          in_fire;
    logic                          s1_advance;
    logic                          emit;
    logic [ccKB_pkg::ADDR_W-1:0]   address;
    logic [ccKB_pkg::DIM_W-1:0]    col_cur;
    logic [ccKB_pkg::DIM_W-1:0]    row_cur;
    logic [ccKB_pkg::DIM_W:0]      col_inc;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ccKB_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= ccKB_pkg::clamp_dim(cfg_data);
                ccKB_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= ccKB_pkg::clamp_dim(cfg_data);
                ccKB_pkg::REG_DST_WIDTH:  cfg_reg.dst_width  <= ccKB_pkg::clamp_dim(cfg_data);
                ccKB_pkg::REG_DST_HEIGHT: cfg_reg.dst_height <= ccKB_pkg::clamp_dim(cfg_data);
                ccKB_pkg::REG_POS_X:      cfg_reg.pos_x <= cfg_data[ccKB_pkg::POS_W-1:0];
                ccKB_pkg::REG_POS_Y:      cfg_reg.pos_y <= cfg_data[ccKB_pkg::POS_W-1:0];
                ccKB_pkg::REG_DST_STRIDE: cfg_reg.dst_stride <= cfg_data[ccKB_pkg::STRIDE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the input register moves on when the result slot is free
    // or being drained this cycle.
    // ------------------------------------------------------------------
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Raster counters: restart on first, step while rows remain
    // ------------------------------------------------------------------
    always_comb
    begin
        col_cur = in_data.first ? '0 : col_count_reg;
        row_cur = in_data.first ? '0 : row_count_reg;
        col_inc = {1'b0, col_cur} + 1'b1;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_fire)
        begin
            col_count_next = col_cur;
            row_count_next = row_cur;
            if (row_cur < cfg_reg.src_height)
            begin
                if (col_inc >= {1'b0, cfg_reg.src_width})
                begin
                    col_count_next = '0;
                    row_count_next = row_cur + 1'b1;
                end
                else
                begin
                    col_count_next = col_inc[ccKB_pkg::DIM_W-1:0];
                end
            end
        end

        s1_next.pixel = in_data.src_pixel;
        s1_next.col   = col_cur;
        s1_next.row   = row_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Clip, key and address
    // ------------------------------------------------------------------
    ccKB_place u_place
    (
        .stage   (s1_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .address (address)
    );

    // ------------------------------------------------------------------
    // Result register: drop pixels that are clipped or transparent
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next.dst_address = address;
        out_next.write_pixel = s1_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_key_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.write_pixel[ccKB_pkg::KEY_W-1:0] != '0)
        else $error("transparent pixel reached the output");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg < ccKB_pkg::MAX_DIM_VAL)
        else $error("column counter out of range");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= ccKB_pkg::MAX_DIM_VAL)
        else $error("row counter out of range");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("input register lost a stalled beat");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with an empty input register");

endmodule

FILE: rtl/ccKB_place.sv
// ============================================================================
// ccKB_place - clip test and destination address for one source pixel
// Offsets the source coordinates, checks the destination bounds and the
// key (a zero low byte), and forms the byte address row*stride + col*4.
// ============================================================================
module ccKB_place
(
    input  ccKB_pkg::ccKB_stage_t          stage,
    input  ccKB_pkg::ccKB_cfg_t            cfg,
    output logic                           emit,
    output logic [ccKB_pkg::ADDR_W-1:0]    address
);

    // Destination coordinates, two's complement, sign in the top bit.
    logic [ccKB_pkg::POS_W:0]                      dx;
    logic [ccKB_pkg::POS_W:0]                      dy;
    logic [ccKB_pkg::DIM_W+ccKB_pkg::STRIDE_W-1:0] row_offset;
    logic [ccKB_pkg::ADDR_W-1:0]                   col_offset;

    always_comb
    begin
        dx = {2'b00, stage.col} + {cfg.pos_x[ccKB_pkg::POS_W-1], cfg.pos_x};
        dy = {2'b00, stage.row} + {cfg.pos_y[ccKB_pkg::POS_W-1], cfg.pos_y};

        emit = (stage.col < cfg.src_width)
            && (stage.row < cfg.src_height)
            && !dx[ccKB_pkg::POS_W]
            && (dx[ccKB_pkg::POS_W-1:0] < {1'b0, cfg.dst_width})
            && !dy[ccKB_pkg::POS_W]
            && (dy[ccKB_pkg::POS_W-1:0] < {1'b0, cfg.dst_height})
            && (stage.pixel[ccKB_pkg::KEY_W-1:0] != '0);

        // Inside the destination both coordinates are below MAX_DIM.
        row_offset = dy[ccKB_pkg::DIM_W-1:0] * cfg.dst_stride;
        col_offset = ccKB_pkg::ADDR_W'({dx[ccKB_pkg::DIM_W-1:0], 2'b00});
        address    = row_offset[ccKB_pkg::ADDR_W-1:0] + col_offset;
    end

endmodule
